// ===== src/set_assoc_lru_cache_tag_model_macros.svh =====
// assertion macros shared by the cache tag model rtl
`ifndef SET_ASSOC_LRU_CACHE_TAG_MODEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAG_MODEL_MACROS_SVH

// property that must hold at every edge out of reset
`define SALRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define SALRU_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/salru_pkg.sv =====
// shared types, constants and helpers for the cache tag model
package salru_pkg;

  // field widths fixed by the interface
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SETB_W    = 3;
  localparam int unsigned WAYSCFG_W = 4;
  localparam int unsigned OFS_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 6;
  localparam int unsigned OUT_DAT_W = 104;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

  // sequencer to scan unit
  typedef struct packed {
    logic step;
    logic first;
  } scan_ctl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic hit;
    logic full;
  } scan_stat_t;

  // saturating counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// ===== src/set_assoc_lru_cache_tag_model.sv =====
// Set-associative cache tag model with LRU replacement. Each accepted address is
// split into set index and tag, then the used ways of that set are read one per
// cycle through the single tag/stamp port and fed to a shared compare unit that
// finds a hit, the first free way and the least recently used way in one pass.
// Each access is a scan followed by an update, a modify item making two accesses;
// the update waits while the output register is still held. After reset the
// valid bits are swept clear set by set, and no item is taken until the sweep ends.
// Counters saturate at 2^32 - 1 and the access clock wraps.
`include "set_assoc_lru_cache_tag_model_macros.svh"

module set_assoc_lru_cache_tag_model
  import salru_pkg::*;
#(
  parameter int unsigned MAX_SETS = 64,
  parameter int unsigned MAX_WAYS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input item
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [ADDR_W-1:0]    s_axis_tdata_i,   // address[63:0]
  input  logic [0:0]           s_axis_tuser_i,   // mode[0]
  // result item
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // was_hit[0], was_eviction[1], hit_total[33:2], miss_total[65:34],
  // eviction_total[97:66], zero[103:98]
  output logic [OUT_DAT_W-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o,   // last_of_item
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned SW = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WW = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAYS + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SPLIT  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;

  logic [2:0]           st_q, st_d;
  logic [SETB_W-1:0]    cfg_sb_q;
  logic [WAYSCFG_W-1:0] cfg_ways_q;
  logic [OFS_W-1:0]     cfg_ob_q;

  logic [ADDR_W-1:0]    shifted_q, shifted_d;
  logic [ADDR_W-1:0]    tag_q, tag_d;
  logic [SW-1:0]        set_q, set_d;
  logic                 second_q, second_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [WW-1:0]        rd_way_q;
  logic                 rd_vld_q;

  logic [STAMP_W-1:0]   clock_q, clock_d;
  logic [CNT_W-1:0]     hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]     miss_cnt_q, miss_cnt_d;
  logic [CNT_W-1:0]     evict_cnt_q, evict_cnt_d;

  logic                 out_vld_q;
  logic                 out_hit_q, out_evict_q, out_last_q;
  logic [CNT_W-1:0]     out_hit_tot_q, out_miss_tot_q, out_evict_tot_q;

  logic [SETB_W-1:0]    sb_eff;
  logic [CW-1:0]        ways_eff;
  logic [SW-1:0]        set_mask;
  logic                 in_xfer, out_free, issue, do_update;
  logic [WW-1:0]        rd_way;

  logic                 st_busy;
  logic [ADDR_W-1:0]    line_tag;
  logic [STAMP_W-1:0]   line_stamp;
  logic                 line_valid;
  scan_ctl_t            scan_ctl;
  scan_stat_t           scan_stat;
  logic [WW-1:0]        scan_way;

  // index bits limited to what the set count holds
  always_comb begin
    sb_eff = '0;
    for (int i = 0; i < 8; i++) begin
      if ((SETB_W'(i) <= cfg_sb_q) && ((1 << i) <= MAX_SETS)) begin
        sb_eff = SETB_W'(i);
      end
    end
  end

  // used ways clamped to one..MAX_WAYS
  always_comb begin
    if (cfg_ways_q == '0) begin
      ways_eff = CW'(1);
    end else if (32'(cfg_ways_q) > MAX_WAYS) begin
      ways_eff = CW'(MAX_WAYS);
    end else begin
      ways_eff = CW'(cfg_ways_q);
    end
  end

  assign set_mask = SW'((64'd1 << sb_eff) - 64'd1);

  // configuration register writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sb_q   <= '0;
      cfg_ways_q <= WAYSCFG_W'(1);
      cfg_ob_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SET_BITS: cfg_sb_q   <= cfg_data_i[SETB_W-1:0];
        CFG_WAYS:     cfg_ways_q <= cfg_data_i[WAYSCFG_W-1:0];
        CFG_OFFSET:   cfg_ob_q   <= cfg_data_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes and scan issue
  assign s_axis_tready_o = (st_q == S_IDLE);
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign issue     = (st_q == S_SCAN) && (cnt_q < ways_eff);
  assign rd_way    = issue ? cnt_q[WW-1:0] : '0;
  assign do_update = (st_q == S_UPDATE) && out_free;

  // sequencer
  always_comb begin
    st_d        = st_q;
    shifted_d   = shifted_q;
    tag_d       = tag_q;
    set_d       = set_q;
    second_d    = second_q;
    cnt_d       = cnt_q;
    clock_d     = clock_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    unique case (st_q)
      S_CLEAR: begin
        if (!st_busy) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          shifted_d = s_axis_tdata_i >> cfg_ob_q;
          second_d  = s_axis_tuser_i[0];
          st_d      = S_SPLIT;
        end
      end
      S_SPLIT: begin
        set_d = shifted_q[SW-1:0] & set_mask;
        tag_d = shifted_q >> sb_eff;
        cnt_d = '0;
        st_d  = S_SCAN;
      end
      S_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          st_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          clock_d = clock_q + 1'b1;
          if (scan_stat.hit) begin
            hit_cnt_d = sat_inc(hit_cnt_q);
          end else begin
            miss_cnt_d = sat_inc(miss_cnt_q);
            if (scan_stat.full) begin
              evict_cnt_d = sat_inc(evict_cnt_q);
            end
          end
          if (second_q) begin
            second_d = 1'b0;
            cnt_d    = '0;
            st_d     = S_SCAN;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      second_q    <= 1'b0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_way_q    <= '0;
      clock_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      st_q        <= st_d;
      second_q    <= second_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= issue;
      rd_way_q    <= rd_way;
      clock_q     <= clock_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
    end
  end

  // address split registers
  always_ff @(posedge clk_i) begin
    shifted_q <= shifted_d;
    tag_q     <= tag_d;
    set_q     <= set_d;
  end

  // line storage
  salru_store #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (st_busy),
    .rd_set_i   (set_q),
    .rd_way_i   (rd_way),
    .rd_tag_o   (line_tag),
    .rd_stamp_o (line_stamp),
    .rd_valid_o (line_valid),
    .wr_en_i    (do_update),
    .wr_set_i   (set_q),
    .wr_way_i   (scan_way),
    .wr_tag_i   (tag_q),
    .wr_stamp_i (clock_q)
  );

  // way scan, one read way per step
  assign scan_ctl.step  = rd_vld_q;
  assign scan_ctl.first = (rd_way_q == '0);

  salru_scan #(
    .MAX_WAYS(MAX_WAYS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .way_i        (rd_way_q),
    .valid_i      (line_valid),
    .line_tag_i   (line_tag),
    .key_tag_i    (tag_q),
    .line_stamp_i (line_stamp),
    .clock_i      (clock_q),
    .stat_o       (scan_stat),
    .way_o        (scan_way)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (do_update) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update) begin
      out_hit_q       <= scan_stat.hit;
      out_evict_q     <= !scan_stat.hit && scan_stat.full;
      out_last_q      <= !second_q;
      out_hit_tot_q   <= hit_cnt_d;
      out_miss_tot_q  <= miss_cnt_d;
      out_evict_tot_q <= evict_cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'd0, out_evict_tot_q, out_miss_tot_q, out_hit_tot_q,
                            out_evict_q, out_hit_q};

  // checks
  `SALRU_ASSERT(a_scan_bound, (st_q != S_SCAN) || (cnt_q <= ways_eff), "scan past used ways")
  `SALRU_ASSERT_NEXT(a_clock_step, do_update,
                     clock_q == $past(clock_q) + 32'd1, "clock not advanced")
  `SALRU_ASSERT_NEXT(a_one_count,
                     do_update && (hit_cnt_q != '1) && (miss_cnt_q != '1),
                     (hit_cnt_q != $past(hit_cnt_q)) != (miss_cnt_q != $past(miss_cnt_q)),
                     "hit and miss counts disagree")
  `SALRU_ASSERT(a_no_busy_item, !(st_busy && s_axis_tready_o), "item taken during clear")

endmodule

// ===== src/salru_store.sv =====
// tag, stamp and valid storage with a clearing sweep after reset
module salru_store
  import salru_pkg::*;
#(
  parameter int unsigned MAX_SETS = 64,
  parameter int unsigned MAX_WAYS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  output logic                                    busy_o,
  input  logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] rd_set_i,
  input  logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] rd_way_i,
  output logic [ADDR_W-1:0]                       rd_tag_o,
  output logic [STAMP_W-1:0]                      rd_stamp_o,
  output logic                                    rd_valid_o,
  input  logic                                    wr_en_i,
  input  logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] wr_set_i,
  input  logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] wr_way_i,
  input  logic [ADDR_W-1:0]                       wr_tag_i,
  input  logic [STAMP_W-1:0]                      wr_stamp_i
);

  localparam int unsigned SW    = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int unsigned DEPTH = MAX_SETS * MAX_WAYS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [ADDR_W-1:0]   tag_mem   [DEPTH];
  logic [STAMP_W-1:0]  stamp_mem [DEPTH];
  logic [MAX_WAYS-1:0] vld_mem   [MAX_SETS];

  logic [AW-1:0]      rd_addr, wr_addr;
  logic [SW-1:0]      clr_q, clr_d;
  logic               busy_q, busy_d;
  logic [ADDR_W-1:0]  rd_tag_q;
  logic [STAMP_W-1:0] rd_stamp_q;
  logic               rd_valid_q;

  // flat line address: set times ways plus way
  assign rd_addr = AW'(rd_set_i) * AW'(MAX_WAYS) + AW'(rd_way_i);
  assign wr_addr = AW'(wr_set_i) * AW'(MAX_WAYS) + AW'(wr_way_i);

  // clearing sweep, one set row per cycle
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (clr_q == SW'(MAX_SETS - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // valid bits, one row per set
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      vld_mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      vld_mem[wr_set_i][wr_way_i] <= 1'b1;
    end
    rd_valid_q <= vld_mem[rd_set_i][rd_way_i];
  end

  // tag and stamp arrays
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_addr]   <= wr_tag_i;
      stamp_mem[wr_addr] <= wr_stamp_i;
    end
    rd_tag_q   <= tag_mem[rd_addr];
    rd_stamp_q <= stamp_mem[rd_addr];
  end

  assign busy_o     = busy_q;
  assign rd_tag_o   = rd_tag_q;
  assign rd_stamp_o = rd_stamp_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== src/salru_scan.sv =====
// shared way scan unit: tag compare, first free way and oldest way
module salru_scan
  import salru_pkg::*;
#(
  parameter int unsigned MAX_WAYS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  scan_ctl_t                               ctl_i,
  input  logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] way_i,
  input  logic                                    valid_i,
  input  logic [ADDR_W-1:0]                       line_tag_i,
  input  logic [ADDR_W-1:0]                       key_tag_i,
  input  logic [STAMP_W-1:0]                      line_stamp_i,
  input  logic [STAMP_W-1:0]                      clock_i,
  output scan_stat_t                              stat_o,
  output logic [(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] way_o
);

  localparam int unsigned WW = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;

  logic               match;
  logic [STAMP_W-1:0] age;
  logic               hit_q, inv_q;
  logic [WW-1:0]      hit_way_q, inv_way_q, vic_way_q;
  logic [STAMP_W-1:0] best_age_q;

  // one way per step: tag match and age since last touch
  assign match = valid_i && (line_tag_i == key_tag_i);
  assign age   = clock_i - line_stamp_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      inv_q      <= 1'b0;
      hit_way_q  <= '0;
      inv_way_q  <= '0;
      vic_way_q  <= '0;
      best_age_q <= '0;
    end else if (ctl_i.step) begin
      if (ctl_i.first) begin
        hit_q      <= match;
        hit_way_q  <= way_i;
        inv_q      <= !valid_i;
        inv_way_q  <= way_i;
        vic_way_q  <= way_i;
        best_age_q <= age;
      end else begin
        // lowest matching way wins
        if (!hit_q && match) begin
          hit_q     <= 1'b1;
          hit_way_q <= way_i;
        end
        // lowest free way
        if (!inv_q && !valid_i) begin
          inv_q     <= 1'b1;
          inv_way_q <= way_i;
        end
        // strictly older replaces, so ties keep the lower way
        if (age > best_age_q) begin
          best_age_q <= age;
          vic_way_q  <= way_i;
        end
      end
    end
  end

  assign stat_o.hit  = hit_q;
  assign stat_o.full = !inv_q;
  assign way_o = hit_q ? hit_way_q : (inv_q ? inv_way_q : vic_way_q);

endmodule

// ===== sim/set_assoc_lru_cache_tag_model_tb.sv =====
// testbench for the set-associative lru cache tag model: stream stimulus, tag model, result check
module set_assoc_lru_cache_tag_model_tb;
  import salru_pkg::*;

  localparam int unsigned SET_COUNT      = 64;
  localparam int unsigned WAY_COUNT      = 8;
  localparam int unsigned PHASE_ITEMS    = 110;
  localparam int unsigned CFG_SETTLE     = 24;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_COUNT    = 8;
  localparam int unsigned TAG_POOL_SIZE  = 10;

  // index with no register behind it, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              modify;
  } access_item_t;

  typedef struct packed {
    logic             hit;
    logic             evict;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
    logic             last;
  } access_result_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [ADDR_W-1:0]    s_axis_tdata_i  = '0;   // address[63:0]
  logic [0:0]           s_axis_tuser_i  = '0;   // mode[0]
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  // was_hit[0], was_eviction[1], hit_total[33:2], miss_total[65:34],
  // eviction_total[97:66], zero[103:98]
  logic [OUT_DAT_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;         // last_of_item
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i      = '0;

  set_assoc_lru_cache_tag_model #(
    .MAX_SETS(SET_COUNT),
    .MAX_WAYS(WAY_COUNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // tag store and counters of the predictor
  bit                line_valid [SET_COUNT*WAY_COUNT];
  logic [ADDR_W-1:0] line_tag   [SET_COUNT*WAY_COUNT];
  logic [STAMP_W-1:0] line_stamp[SET_COUNT*WAY_COUNT];
  logic [STAMP_W-1:0] access_clock   = '0;
  logic [CNT_W-1:0]   hit_count      = '0;
  logic [CNT_W-1:0]   miss_count     = '0;
  logic [CNT_W-1:0]   eviction_count = '0;

  // register copies seen by the predictor
  logic [SETB_W-1:0]    model_set_bits = '0;
  logic [WAYSCFG_W-1:0] model_ways     = 4'd1;
  logic [OFS_W-1:0]     model_offset   = '0;

  access_item_t   access_queue[$];
  access_result_t pending_results[$];
  int unsigned    items_sent  = 0;
  int unsigned    items_taken = 0;
  int unsigned    error_count = 0;
  int unsigned    idle_cycles = 0;
  bit             quiet        = 1'b0;
  bit             hold_request = 1'b0;
  bit             hold_done    = 1'b0;
  int unsigned    hold_left    = 0;

  logic [ADDR_W-1:0] tag_pool[TAG_POOL_SIZE];
  logic [ADDR_W-1:0] set_pool[2];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // index bits actually used, shrunk until the set count fits
  function automatic int unsigned eff_set_bits();
    int unsigned sb;
    sb = model_set_bits;
    while (sb > 0 && (1 << sb) > SET_COUNT) sb--;
    return sb;
  endfunction

  function automatic int unsigned eff_ways();
    if (model_ways == 0) return 1;
    if (model_ways > WAY_COUNT) return WAY_COUNT;
    return model_ways;
  endfunction

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // one lookup with fill or lru replacement, returns the result of the access
  function automatic access_result_t cache_access(input logic [ADDR_W-1:0] addr);
    access_result_t    r;
    int unsigned       sb, ob, ways, set_idx, base, victim;
    logic [ADDR_W-1:0] tag;
    logic [STAMP_W-1:0] age, oldest;
    sb      = eff_set_bits();
    ob      = model_offset;
    ways    = eff_ways();
    set_idx = 32'((addr >> ob) & ((64'd1 << sb) - 64'd1));
    tag     = (ob + sb >= ADDR_W) ? '0 : addr >> (ob + sb);
    base    = set_idx * WAY_COUNT;
    r       = '0;

    // search the used ways for a matching valid line
    for (int w = 0; w < ways; w++) begin
      if (!r.hit && line_valid[base + w] && line_tag[base + w] == tag) begin
        line_stamp[base + w] = access_clock;
        access_clock++;
        hit_count = count_up(hit_count);
        r.hit     = 1'b1;
      end
    end

    if (!r.hit) begin
      miss_count = count_up(miss_count);
      // lowest free way first
      victim = ways;
      for (int w = ways - 1; w >= 0; w--) begin
        if (!line_valid[base + w]) victim = w;
      end
      // set full: oldest stamp goes, lowest way on a tie
      if (victim == ways) begin
        victim = 0;
        oldest = access_clock - line_stamp[base];
        for (int w = 1; w < ways; w++) begin
          age = access_clock - line_stamp[base + w];
          if (age > oldest) begin
            oldest = age;
            victim = w;
          end
        end
        eviction_count = count_up(eviction_count);
        r.evict        = 1'b1;
      end
      line_valid[base + victim] = 1'b1;
      line_tag[base + victim]   = tag;
      line_stamp[base + victim] = access_clock;
      access_clock++;
    end

    r.hits      = hit_count;
    r.misses    = miss_count;
    r.evictions = eviction_count;
    return r;
  endfunction

  // mostly addresses built from a few sets and tags, the rest fully random
  function automatic logic [ADDR_W-1:0] make_address();
    int unsigned       sb, ob;
    logic [ADDR_W-1:0] a, ofs_mask, tag_part;
    sb = eff_set_bits();
    ob = model_offset;
    a  = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 82) begin
      ofs_mask = (64'd1 << ob) - 1;
      tag_part = (ob + sb >= ADDR_W) ? '0 :
                 tag_pool[$urandom_range(0, eff_ways() + 1)] << (ob + sb);
      a = (a & ofs_mask) | (set_pool[$urandom_range(0, 1)] << ob) | tag_part;
    end
    return a;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // input driver, one new item at most per falling edge
  always @(negedge clk_i) begin
    access_item_t item;
    if (!s_axis_tvalid_i || items_taken == items_sent) begin
      if (access_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
        item = access_queue.pop_front();
        s_axis_tdata_i  <= item.addr;
        s_axis_tuser_i  <= item.modify;
        s_axis_tvalid_i <= 1'b1;
        items_sent++;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_request && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= quiet || ($urandom_range(0, 99) >= 7);
    end
  end

  // monitor: check results, predict accepted items, track register writes
  always @(posedge clk_i) begin
    access_result_t want;
    access_result_t got;
    int unsigned    n;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.hit       = m_axis_tdata_o[0];
        got.evict     = m_axis_tdata_o[1];
        got.hits      = m_axis_tdata_o[33:2];
        got.misses    = m_axis_tdata_o[65:34];
        got.evictions = m_axis_tdata_o[97:66];
        got.last      = m_axis_tlast_o;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: data %h last %b",
                 m_axis_tdata_o, m_axis_tlast_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("was_hit", want.hit, got.hit);
          check_field("was_eviction", want.evict, got.evict);
          check_field("hit_total", want.hits, got.hits);
          check_field("miss_total", want.misses, got.misses);
          check_field("eviction_total", want.evictions, got.evictions);
          check_field("last_of_item", want.last, got.last);
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_o) begin
        n = s_axis_tuser_i[0] ? 2 : 1;
        for (int k = 0; k < n; k++) begin
          want      = cache_access(s_axis_tdata_i);
          want.last = (k == n - 1);
          pending_results.push_back(want);
        end
        items_taken++;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SET_BITS: model_set_bits = cfg_data_i[SETB_W-1:0];
          CFG_WAYS:     model_ways     = cfg_data_i[WAYSCFG_W-1:0];
          CFG_OFFSET:   model_offset   = cfg_data_i[OFS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (access_queue.size() != 0 || items_taken != items_sent ||
           pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (CFG_SETTLE) @(negedge clk_i);
  endtask

  task automatic push_item(input logic [ADDR_W-1:0] addr, input logic modify);
    access_item_t item;
    item.addr   = addr;
    item.modify = modify;
    access_queue.push_back(item);
  endtask

  // register settings per phase, raw data so unused upper bits get exercised
  logic [CFG_DAT_W-1:0] set_bits_raw[PHASE_COUNT] = '{6'd6, 6'h3F, 6'd0, 6'd3,
                                                      6'd2, 6'd6, 6'd1, 6'h3E};
  logic [CFG_DAT_W-1:0] ways_raw[PHASE_COUNT]     = '{6'd8, 6'h2F, 6'd0, 6'd4,
                                                      6'd2, 6'd8, 6'd3, 6'h11};
  logic [CFG_DAT_W-1:0] offset_raw[PHASE_COUNT]   = '{6'd6, 6'd0, 6'd63, 6'd5,
                                                      6'd32, 6'd58, 6'd12, 6'd0};

  initial begin
    foreach (line_valid[i]) line_valid[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: one set, one way, the whole address is the tag
    push_item('0, 1'b0);                   // cold miss
    push_item('0, 1'b0);                   // hit
    push_item('0, 1'b1);                   // modify, two hits
    push_item('1, 1'b0);                   // miss replacing a valid line
    push_item('1, 1'b1);                   // modify on a resident line
    push_item(64'h8000_0000_0000_0000, 1'b1);  // modify miss then hit
    push_item(64'h1, 1'b0);
    push_item('0, 1'b1);
    push_item(64'h5555_5555_5555_5555, 1'b0);
    push_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    push_item(64'h0000_0000_FFFF_FFFF, 1'b1);
    push_item(64'hFFFF_FFFF_0000_0000, 1'b0);
    wait_drained();

    // random phases, one register setting each
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_cfg(CFG_SET_BITS, set_bits_raw[p]);
      write_cfg(CFG_WAYS, ways_raw[p]);
      write_cfg(CFG_OFFSET, offset_raw[p]);
      if (p == 0) write_cfg(CFG_NONE, 6'h3F);
      for (int i = 0; i < TAG_POOL_SIZE; i++) begin
        tag_pool[i] = (i < 5) ? 64'(i) : {$urandom, $urandom};
      end
      for (int i = 0; i < 2; i++) begin
        set_pool[i] = 64'($urandom_range(0, (1 << eff_set_bits()) - 1));
      end
      quiet = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_item(make_address(), 1'($urandom_range(0, 1)));
      end
      // long receiver hold-off while items keep coming
      if (p == 3) hold_request = 1'b1;
      wait_drained();
      quiet = 1'b0;
    end

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== set_assoc_lru_cache_tag_model.f =====
+incdir+src
src/salru_pkg.sv
src/salru_store.sv
src/salru_scan.sv
src/set_assoc_lru_cache_tag_model.sv
sim/set_assoc_lru_cache_tag_model_tb.sv
